// ===== sv/ffha_pkg.sv =====
package ffha_pkg;

  // request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_CHK,
    ST_A_REST,
    ST_A_PRV,
    ST_F_CHK,
    ST_F_WALK,
    ST_F_MRGN,
    ST_F_WUNIT,
    ST_F_WPRV,
    ST_DONE
  } state_e;

endpackage

// ===== sv/ffha_if.sv =====
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] request_bytes;
  logic [15:0] free_address;
  modport source (output valid, mode, request_bytes, free_address, input ready);
  modport sink (input valid, mode, request_bytes, free_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_address;
  logic        ok;
  modport source (output valid, data_address, ok, input ready);
  modport sink (input valid, data_address, ok, output ready);
endinterface

// ===== sv/first_fit_heap_allocator.sv =====
// allocate: ST_A_CHK reads free blocks in list order until one fits, ST_A_REST writes a split remainder
// and ST_A_PRV relinks a previous block; a refused allocate reads every free block (none if too large)
// free: headers are read up to the insert point, then merged and relinked; an ignored free skips both
// throughput: one request in flight; the next request beat follows the response beat
// reset: asynchronous; the whole heap is one free block at unit 0, list head unit 0
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);
  localparam int Units = HEAP_BYTES / 16;
  localparam int UW = $clog2(Units) + 1;   // unit code incl. none link
  localparam int AW = $clog2(Units);
  localparam logic [UW-1:0] NoneLink = UW'(Units);

  // header memory: size, link, used mark
  typedef struct packed {
    logic [UW-1:0] size;
    logic [UW-1:0] link;
    logic          used;
  } hdr_t;

  hdr_t hdr_mem [Units];
  hdr_t rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  hdr_t          wd;

  // unit 0 initialized by a one-entry override until first write
  logic zero_valid_q;
  logic rd_zero_q;
  hdr_t rdat;

  ffha_pkg::state_e st_q, st_d;
  logic [UW-1:0] head_q, head_d, cur_q, cur_d, prv_q, prv_d, need_q, need_d, unit_q, unit_d;
  hdr_t prv_h_q, prv_h_d, unit_h_q, unit_h_d;
  logic [15:0] out_addr_q, out_addr_d;
  logic out_ok_q, out_ok_d;

  logic [16:0]   need_w;
  logic [11:0]   fu_w;
  logic          need_big_w, free_bad_w, fits_w, split_w, walk_stop_w, new_head_w;
  logic [UW-1:0] nxt_size_w, nxt_link_w;
  logic          mrg_next_w, mrg_prev_w;

  function automatic logic vld(logic [UW-1:0] u);
    return u < UW'(Units);
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) hdr_mem[wa] <= wd;
    rd_q <= hdr_mem[ra];
  end

  always_comb begin
    rdat = rd_q;
    if (rd_zero_q && !zero_valid_q) begin
      rdat.size = UW'(Units);
      rdat.link = NoneLink;
      rdat.used = 1'b0;
    end
  end

  assign req.ready = (st_q == ffha_pkg::ST_IDLE);
  assign rsp.valid = (st_q == ffha_pkg::ST_DONE);
  assign rsp.data_address = out_addr_q;
  assign rsp.ok = out_ok_q;

  // request decode and header tests
  assign need_w = ({1'b0, req.request_bytes} + 17'd15) >> 4;
  assign need_big_w = (need_w + 17'd1) > 17'(Units);
  assign fu_w = req.free_address[15:4];
  assign free_bad_w = (fu_w == 12'd0) || (32'(fu_w) > 32'(Units));
  assign fits_w = rdat.size >= need_q;
  assign split_w = rdat.size != need_q;
  assign walk_stop_w = !vld(rdat.link) || (rdat.link >= unit_q);
  assign new_head_w = !vld(head_q) || (unit_q < head_q);
  assign mrg_prev_w = ({1'b0, prv_q} + {1'b0, prv_h_q.size}) == {1'b0, unit_q};

  // following free block of the freed one and whether they touch
  always_comb begin
    if (st_q == ffha_pkg::ST_F_CHK) begin
      nxt_size_w = rdat.size;
      nxt_link_w = vld(head_q) ? head_q : NoneLink;
    end else begin
      nxt_size_w = unit_h_q.size;
      nxt_link_w = vld(rdat.link) ? rdat.link : NoneLink;
    end
    mrg_next_w = vld(nxt_link_w) &&
                 (({1'b0, unit_q} + {1'b0, nxt_size_w}) == {1'b0, nxt_link_w});
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ffha_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.mode == ffha_pkg::MODE_ALLOC) begin
            st_d = (need_big_w || !vld(head_q)) ? ffha_pkg::ST_DONE : ffha_pkg::ST_A_CHK;
          end else begin
            st_d = free_bad_w ? ffha_pkg::ST_DONE : ffha_pkg::ST_F_CHK;
          end
        end
      end
      ffha_pkg::ST_A_CHK: begin
        if (fits_w) begin
          if (split_w) st_d = ffha_pkg::ST_A_REST;
          else if (prv_q != NoneLink) st_d = ffha_pkg::ST_A_PRV;
          else st_d = ffha_pkg::ST_DONE;
        end else if (!vld(rdat.link)) begin
          st_d = ffha_pkg::ST_DONE;
        end
      end
      ffha_pkg::ST_A_REST: begin
        st_d = (prv_q != NoneLink) ? ffha_pkg::ST_A_PRV : ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_A_PRV: begin
        st_d = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_F_CHK: begin
        if (!rdat.used) st_d = ffha_pkg::ST_DONE;
        else if (new_head_w) begin
          st_d = mrg_next_w ? ffha_pkg::ST_F_MRGN : ffha_pkg::ST_F_WUNIT;
        end else st_d = ffha_pkg::ST_F_WALK;
      end
      ffha_pkg::ST_F_WALK: begin
        if (walk_stop_w) begin
          st_d = mrg_next_w ? ffha_pkg::ST_F_MRGN : ffha_pkg::ST_F_WUNIT;
        end
      end
      ffha_pkg::ST_F_MRGN: begin
        st_d = ffha_pkg::ST_F_WUNIT;
      end
      ffha_pkg::ST_F_WUNIT: begin
        st_d = (prv_q != NoneLink) ? ffha_pkg::ST_F_WPRV : ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_F_WPRV: begin
        st_d = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_DONE: begin
        if (rsp.ready) st_d = ffha_pkg::ST_IDLE;
      end
      default: st_d = ffha_pkg::ST_IDLE;
    endcase
  end

  // memory access and working registers
  always_comb begin
    head_d = head_q; cur_d = cur_q; prv_d = prv_q; need_d = need_q; unit_d = unit_q;
    prv_h_d = prv_h_q; unit_h_d = unit_h_q;
    out_addr_d = out_addr_q; out_ok_d = out_ok_q;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    case (st_q)
      ffha_pkg::ST_IDLE: begin
        if (req.valid) begin
          out_addr_d = '0; out_ok_d = 1'b1;
          if (req.mode == ffha_pkg::MODE_ALLOC) begin
            need_d = UW'(need_w + 17'd1);
            prv_d = NoneLink; cur_d = head_q; ra = head_q[AW-1:0];
            if (need_big_w || !vld(head_q)) out_ok_d = 1'b0;
          end else begin
            unit_d = UW'(fu_w - 12'd1);
            ra = AW'(fu_w - 12'd1);
          end
        end
      end
      ffha_pkg::ST_A_CHK: begin
        if (fits_w) begin
          // take this block, split off the remainder when larger
          we = 1'b1; wa = cur_q[AW-1:0];
          wd = '{size: need_q, link: rdat.link, used: 1'b1};
          out_addr_d = {12'(cur_q + UW'(1)), 4'b0000};
          unit_d = split_w ? UW'(cur_q + need_q) : rdat.link;
          unit_h_d = '{size: UW'(rdat.size - need_q), link: rdat.link, used: 1'b0};
          if (prv_q == NoneLink) head_d = split_w ? UW'(cur_q + need_q) : rdat.link;
        end else begin
          // too small, move on and keep this header for the relink
          prv_d = cur_q; prv_h_d = rdat; cur_d = rdat.link;
          ra = rdat.link[AW-1:0];
          if (!vld(rdat.link)) out_ok_d = 1'b0;
        end
      end
      ffha_pkg::ST_A_REST: begin
        we = 1'b1; wa = unit_q[AW-1:0]; wd = unit_h_q;
      end
      ffha_pkg::ST_A_PRV: begin
        we = 1'b1; wa = prv_q[AW-1:0];
        wd = '{size: prv_h_q.size, link: unit_q, used: prv_h_q.used};
      end
      ffha_pkg::ST_F_CHK: begin
        if (rdat.used) begin
          unit_h_d = '{size: rdat.size, link: NoneLink, used: 1'b0};
          if (new_head_w) begin
            head_d = unit_q; prv_d = NoneLink;
            unit_h_d.link = nxt_link_w; ra = nxt_link_w[AW-1:0];
          end else begin
            cur_d = head_q; ra = head_q[AW-1:0];
          end
        end
      end
      ffha_pkg::ST_F_WALK: begin
        // rdat is header of cur
        if (walk_stop_w) begin
          prv_d = cur_q; prv_h_d = rdat;
          unit_h_d.link = nxt_link_w; ra = nxt_link_w[AW-1:0];
        end else begin
          cur_d = rdat.link; ra = rdat.link[AW-1:0];
        end
      end
      ffha_pkg::ST_F_MRGN: begin
        // rdat is header of the following free block
        unit_h_d.size = UW'(unit_h_q.size + rdat.size);
        unit_h_d.link = rdat.link;
      end
      ffha_pkg::ST_F_WUNIT: begin
        we = 1'b1; wa = unit_q[AW-1:0]; wd = unit_h_q;
      end
      ffha_pkg::ST_F_WPRV: begin
        we = 1'b1; wa = prv_q[AW-1:0];
        if (mrg_prev_w) begin
          // merge into previous block
          wd = '{size: UW'(prv_h_q.size + unit_h_q.size), link: unit_h_q.link,
                 used: prv_h_q.used};
        end else begin
          wd = '{size: prv_h_q.size, link: unit_q, used: prv_h_q.used};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ffha_pkg::ST_IDLE;
      head_q <= '0;
      zero_valid_q <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      st_q <= st_d;
      head_q <= head_d;
      if (we && (wa == '0)) zero_valid_q <= 1'b1;
      rd_zero_q <= (ra == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; prv_q <= prv_d; need_q <= need_d; unit_q <= unit_d;
    prv_h_q <= prv_h_d; unit_h_q <= unit_h_d;
    out_addr_q <= out_addr_d; out_ok_q <= out_ok_d;
  end

endmodule
